// File: hdl/cpcc_pkg.sv
// ----------------------------------------------------------------------------
// cpcc_pkg
// Shared constants for the cubic polynomial color correction pipeline.
// ----------------------------------------------------------------------------
package cpcc_pkg;

    // Default widths of the pixel components and of one coefficient.
    localparam int PIXEL_BITS_DEF = 8;
    localparam int COEF_BITS_DEF  = 40;

    // Coefficients carry a fixed binary point with this many fraction bits.
    localparam int FRAC_BITS = 32;

    localparam int N_CHAN  = 3;
    localparam int N_TERMS = 9;
    localparam int N_COEF  = N_CHAN * N_TERMS;
    localparam int IDX_W   = 5;

    // Item action codes.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

endpackage

// File: hdl/cpcc_if.sv
// ----------------------------------------------------------------------------
// cpcc_if
// Valid/ready stream interfaces for the color correction items and results.
// ----------------------------------------------------------------------------
interface cpcc_in_if #(
    parameter int PIXEL_BITS = cpcc_pkg::PIXEL_BITS_DEF,
    parameter int COEF_BITS  = cpcc_pkg::COEF_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [cpcc_pkg::IDX_W-1:0]        coef_index;
    logic signed [COEF_BITS-1:0]       coef_value;
    logic [PIXEL_BITS-1:0]             in_red;
    logic [PIXEL_BITS-1:0]             in_green;
    logic [PIXEL_BITS-1:0]             in_blue;

    modport source (
        output valid, action, coef_index, coef_value, in_red, in_green, in_blue,
        input  ready
    );
    modport sink (
        input  valid, action, coef_index, coef_value, in_red, in_green, in_blue,
        output ready
    );
endinterface

interface cpcc_out_if #(
    parameter int PIXEL_BITS = cpcc_pkg::PIXEL_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] out_red;
    logic [PIXEL_BITS-1:0] out_green;
    logic [PIXEL_BITS-1:0] out_blue;

    modport source (
        output valid, out_red, out_green, out_blue,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue,
        output ready
    );
endinterface

// File: hdl/cubic_polynomial_color_correction_unit.sv
// ----------------------------------------------------------------------------
// cubic_polynomial_color_correction_unit
// Cubic polynomial color correction of an RGB pixel stream.
// ----------------------------------------------------------------------------
// The feed channel carries two kinds of item. A write item (action 0) loads
// one signed coefficient with 32 fraction bits into entry coef_index of the
// 27-entry table (channel times 9 plus term) and produces no result; indexes
// above 26 are ignored. A pixel item (action 1) produces one corrected pixel
// on the result channel: each output is the sum of the nine terms r, g, b,
// their squares and cubes, each weighted by its coefficient, rounded half up
// and clamped to the pixel range.
// One item is accepted every clock while the result channel keeps up. The
// pipeline has eight stages: input register, squares, cubes, split
// products, product merge, two adder tree stages and the output register.
// A write takes effect as it leaves the cube stage, in order with the pixels
// around it. Reset clears all coefficients to zero and empties the pipeline.
// When the receiver stalls, the result is held and the stages fill up one by
// one; feed ready drops only once every stage holds an item.
// ----------------------------------------------------------------------------
module cubic_polynomial_color_correction_unit #(
    parameter int PIXEL_BITS = cpcc_pkg::PIXEL_BITS_DEF,
    parameter int COEF_BITS  = cpcc_pkg::COEF_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    cpcc_in_if.sink      feed,
    cpcc_out_if.source   result
);

    // Every term fits in three pixel widths; the sum of nine products needs
    // a few guard bits on top of one product.
    localparam int TERM_W = 3 * PIXEL_BITS;
    localparam int ACC_W  = COEF_BITS + TERM_W + 5;

    logic                        term_valid;
    logic                        term_ready;
    logic                        term_action;
    logic [cpcc_pkg::IDX_W-1:0]  term_index;
    logic [COEF_BITS-1:0]        term_value;
    logic [TERM_W-1:0]           terms [cpcc_pkg::N_TERMS];
    logic                        sum_valid;
    logic                        sum_ready;
    logic signed [ACC_W-1:0]     sums [cpcc_pkg::N_CHAN];
    logic [PIXEL_BITS-1:0]       pix_rgb [cpcc_pkg::N_CHAN];
    logic [PIXEL_BITS-1:0]       res_rgb [cpcc_pkg::N_CHAN];

    assign pix_rgb[0] = feed.in_red;
    assign pix_rgb[1] = feed.in_green;
    assign pix_rgb[2] = feed.in_blue;

    // Stages 1 to 3: register the item, then build squares and cubes.
    cpcc_terms #(
        .PIXEL_BITS (PIXEL_BITS),
        .COEF_BITS  (COEF_BITS),
        .TERM_W     (TERM_W)
    ) u_terms (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (feed.valid),
        .pix_ready   (feed.ready),
        .pix_action  (feed.action),
        .pix_index   (feed.coef_index),
        .pix_value   (feed.coef_value),
        .pix_rgb     (pix_rgb),
        .term_valid  (term_valid),
        .term_ready  (term_ready),
        .term_action (term_action),
        .term_index  (term_index),
        .term_value  (term_value),
        .terms       (terms)
    );

    // Stages 4 to 7: coefficient table, products and the adder tree.
    cpcc_mac #(
        .PIXEL_BITS (PIXEL_BITS),
        .COEF_BITS  (COEF_BITS),
        .TERM_W     (TERM_W),
        .ACC_W      (ACC_W)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .term_valid  (term_valid),
        .term_ready  (term_ready),
        .term_action (term_action),
        .term_index  (term_index),
        .term_value  (term_value),
        .terms       (terms),
        .sum_valid   (sum_valid),
        .sum_ready   (sum_ready),
        .sums        (sums)
    );

    // Stage 8: drop the fraction, clamp, and hold the result for the sink.
    cpcc_round #(
        .PIXEL_BITS (PIXEL_BITS),
        .ACC_W      (ACC_W)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sums      (sums),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res_rgb   (res_rgb)
    );

    assign result.out_red   = res_rgb[0];
    assign result.out_green = res_rgb[1];
    assign result.out_blue  = res_rgb[2];

endmodule

// File: hdl/cpcc_terms.sv
// ----------------------------------------------------------------------------
// cpcc_terms
// Input register and the two stages that build squares and cubes.
// ----------------------------------------------------------------------------
module cpcc_terms #(
    parameter int PIXEL_BITS = cpcc_pkg::PIXEL_BITS_DEF,
    parameter int COEF_BITS  = cpcc_pkg::COEF_BITS_DEF,
    parameter int TERM_W     = 3 * PIXEL_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  logic                          pix_action,
    input  logic [cpcc_pkg::IDX_W-1:0]    pix_index,
    input  logic [COEF_BITS-1:0]          pix_value,
    input  logic [PIXEL_BITS-1:0]         pix_rgb [cpcc_pkg::N_CHAN],
    output logic                          term_valid,
    input  logic                          term_ready,
    output logic                          term_action,
    output logic [cpcc_pkg::IDX_W-1:0]    term_index,
    output logic [COEF_BITS-1:0]          term_value,
    output logic [TERM_W-1:0]             terms [cpcc_pkg::N_TERMS]
);

    localparam int SQ_W = 2 * PIXEL_BITS;

    logic                        v1_reg, v2_reg, v3_reg;
    logic                        rdy1, rdy2, rdy3;
    logic                        act1_reg, act2_reg, act3_reg;
    logic [cpcc_pkg::IDX_W-1:0]  idx1_reg, idx2_reg, idx3_reg;
    logic [COEF_BITS-1:0]        val1_reg, val2_reg, val3_reg;
    logic [PIXEL_BITS-1:0]       lin1_reg [cpcc_pkg::N_CHAN];
    logic [PIXEL_BITS-1:0]       lin2_reg [cpcc_pkg::N_CHAN];
    logic [SQ_W-1:0]             sq2_reg  [cpcc_pkg::N_CHAN];
    logic [TERM_W-1:0]           term3_reg [cpcc_pkg::N_TERMS];

    assign rdy3      = !v3_reg || term_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign pix_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= pix_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            act1_reg <= pix_action;
            idx1_reg <= pix_index;
            val1_reg <= pix_value;
            for (int c = 0; c < cpcc_pkg::N_CHAN; c++)
            begin
                lin1_reg[c] <= pix_rgb[c];
            end
        end
        if (rdy2)
        begin
            act2_reg <= act1_reg;
            idx2_reg <= idx1_reg;
            val2_reg <= val1_reg;
            for (int c = 0; c < cpcc_pkg::N_CHAN; c++)
            begin
                lin2_reg[c] <= lin1_reg[c];
                sq2_reg[c]  <= SQ_W'(lin1_reg[c]) * SQ_W'(lin1_reg[c]);
            end
        end
        if (rdy3)
        begin
            act3_reg <= act2_reg;
            idx3_reg <= idx2_reg;
            val3_reg <= val2_reg;
            // Term order: linear r,g,b, then squares, then cubes.
            for (int c = 0; c < cpcc_pkg::N_CHAN; c++)
            begin
                term3_reg[c]                      <= TERM_W'(lin2_reg[c]);
                term3_reg[cpcc_pkg::N_CHAN + c]   <= TERM_W'(sq2_reg[c]);
                term3_reg[2*cpcc_pkg::N_CHAN + c] <= TERM_W'(sq2_reg[c]) *
                                                     TERM_W'(lin2_reg[c]);
            end
        end
    end

    assign term_valid  = v3_reg;
    assign term_action = act3_reg;
    assign term_index  = idx3_reg;
    assign term_value  = val3_reg;
    assign terms       = term3_reg;

endmodule

// File: hdl/cpcc_mac.sv
// ----------------------------------------------------------------------------
// cpcc_mac
// Coefficient table, split products and the registered adder tree.
// ----------------------------------------------------------------------------
module cpcc_mac #(
    parameter int PIXEL_BITS = cpcc_pkg::PIXEL_BITS_DEF,
    parameter int COEF_BITS  = cpcc_pkg::COEF_BITS_DEF,
    parameter int TERM_W     = 3 * PIXEL_BITS,
    parameter int ACC_W      = COEF_BITS + TERM_W + 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          term_valid,
    output logic                          term_ready,
    input  logic                          term_action,
    input  logic [cpcc_pkg::IDX_W-1:0]    term_index,
    input  logic [COEF_BITS-1:0]          term_value,
    input  logic [TERM_W-1:0]             terms [cpcc_pkg::N_TERMS],
    output logic                          sum_valid,
    input  logic                          sum_ready,
    output logic signed [ACC_W-1:0]       sums [cpcc_pkg::N_CHAN]
);

    // Each coefficient is split into an unsigned low half and a signed high
    // half so that no single multiplier grows past about 32 by 32 bits.
    localparam int LO_W   = COEF_BITS / 2;
    localparam int HI_W   = COEF_BITS - LO_W;
    localparam int LOP_W  = LO_W + TERM_W;
    localparam int HIP_W  = HI_W + TERM_W + 1;
    localparam int PROD_W = COEF_BITS + TERM_W + 1;
    localparam int NG     = cpcc_pkg::N_TERMS / 3;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (cpcc_pkg::FRAC_BITS - 1);

    logic [COEF_BITS-1:0]      coef_reg [cpcc_pkg::N_COEF];
    logic                      v4_reg, v5_reg, v6_reg, v7_reg;
    logic                      rdy4, rdy5, rdy6, rdy7;
    logic                      coef_wr;
    logic [LOP_W-1:0]          lop4_reg  [cpcc_pkg::N_CHAN][cpcc_pkg::N_TERMS];
    logic signed [HIP_W-1:0]   hip4_reg  [cpcc_pkg::N_CHAN][cpcc_pkg::N_TERMS];
    logic signed [PROD_W-1:0]  prod5_reg [cpcc_pkg::N_CHAN][cpcc_pkg::N_TERMS];
    logic signed [ACC_W-1:0]   part6_reg [cpcc_pkg::N_CHAN][NG];
    logic signed [ACC_W-1:0]   sum7_reg  [cpcc_pkg::N_CHAN];

    assign rdy7       = !v7_reg || sum_ready;
    assign rdy6       = !v6_reg || rdy7;
    assign rdy5       = !v5_reg || rdy6;
    assign rdy4       = !v4_reg || rdy5;
    assign term_ready = rdy4;

    // The table is written as a write item leaves the term stages, so every
    // pixel sees exactly the writes that were accepted before it.
    assign coef_wr = term_valid && rdy4 && (term_action == cpcc_pkg::ACT_WRITE) &&
                     (term_index < cpcc_pkg::IDX_W'(cpcc_pkg::N_COEF));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cpcc_pkg::N_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (coef_wr)
        begin
            coef_reg[term_index] <= term_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
            begin
                // Write items end here and leave a bubble behind them.
                v4_reg <= term_valid && (term_action == cpcc_pkg::ACT_PIXEL);
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
            if (rdy6)
            begin
                v6_reg <= v5_reg;
            end
            if (rdy7)
            begin
                v7_reg <= v6_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            for (int c = 0; c < cpcc_pkg::N_CHAN; c++)
            begin
                for (int t = 0; t < cpcc_pkg::N_TERMS; t++)
                begin
                    lop4_reg[c][t] <= LOP_W'(coef_reg[c*cpcc_pkg::N_TERMS + t][LO_W-1:0]) *
                                      LOP_W'(terms[t]);
                    hip4_reg[c][t] <=
                        HIP_W'($signed(coef_reg[c*cpcc_pkg::N_TERMS + t][COEF_BITS-1:LO_W])) *
                        HIP_W'($signed({1'b0, terms[t]}));
                end
            end
        end
        if (rdy5)
        begin
            for (int c = 0; c < cpcc_pkg::N_CHAN; c++)
            begin
                for (int t = 0; t < cpcc_pkg::N_TERMS; t++)
                begin
                    prod5_reg[c][t] <= $signed({hip4_reg[c][t], {LO_W{1'b0}}}) +
                                       $signed({{(PROD_W-LOP_W){1'b0}}, lop4_reg[c][t]});
                end
            end
        end
        if (rdy6)
        begin
            for (int c = 0; c < cpcc_pkg::N_CHAN; c++)
            begin
                for (int g = 0; g < NG; g++)
                begin
                    part6_reg[c][g] <= ACC_W'(prod5_reg[c][3*g]) +
                                       ACC_W'(prod5_reg[c][3*g + 1]) +
                                       ACC_W'(prod5_reg[c][3*g + 2]);
                end
            end
        end
        if (rdy7)
        begin
            for (int c = 0; c < cpcc_pkg::N_CHAN; c++)
            begin
                sum7_reg[c] <= part6_reg[c][0] + part6_reg[c][1] + part6_reg[c][2] + HALF;
            end
        end
    end

    assign sum_valid = v7_reg;
    assign sums      = sum7_reg;

endmodule

// File: hdl/cpcc_round.sv
// ----------------------------------------------------------------------------
// cpcc_round
// Drops the fraction of each rounded sum, clamps it and holds the result.
// ----------------------------------------------------------------------------
module cpcc_round #(
    parameter int PIXEL_BITS = cpcc_pkg::PIXEL_BITS_DEF,
    parameter int ACC_W      = cpcc_pkg::COEF_BITS_DEF + 3 * cpcc_pkg::PIXEL_BITS_DEF + 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sum_valid,
    output logic                     sum_ready,
    input  logic signed [ACC_W-1:0]  sums [cpcc_pkg::N_CHAN],
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [PIXEL_BITS-1:0]    res_rgb [cpcc_pkg::N_CHAN]
);

    localparam int INT_W = ACC_W - cpcc_pkg::FRAC_BITS;

    logic                   v8_reg;
    logic                   rdy8;
    logic [PIXEL_BITS-1:0]  rgb8_reg  [cpcc_pkg::N_CHAN];
    logic [PIXEL_BITS-1:0]  rgb8_next [cpcc_pkg::N_CHAN];
    logic [INT_W-1:0]       whole     [cpcc_pkg::N_CHAN];

    assign rdy8      = !v8_reg || res_ready;
    assign sum_ready = rdy8;

    always_comb
    begin
        for (int c = 0; c < cpcc_pkg::N_CHAN; c++)
        begin
            whole[c] = sums[c][ACC_W-1:cpcc_pkg::FRAC_BITS];
            if (whole[c][INT_W-1])
            begin
                rgb8_next[c] = '0;
            end
            else if (|whole[c][INT_W-1:PIXEL_BITS])
            begin
                rgb8_next[c] = '1;
            end
            else
            begin
                rgb8_next[c] = whole[c][PIXEL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
        end
        else if (rdy8)
        begin
            v8_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy8)
        begin
            rgb8_reg <= rgb8_next;
        end
    end

    assign res_valid = v8_reg;
    assign res_rgb   = rgb8_reg;

endmodule
